[sv/fatde_pkg.sv]
// shared types, constants and helpers of the fat directory entry parser
package fatde_pkg;

  typedef enum logic [1:0] {
    OP_END,
    OP_FRAG,
    OP_CLEAR,
    OP_SHORT
  } op_e;

  typedef enum logic [1:0] {
    LN_NONE  = 2'd0,
    LN_VALID = 2'd1,
    LN_TRUNC = 2'd2
  } lstat_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_CHUNK  = 2'd1,
    KIND_END    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FRAG,
    BK_CSUM,
    BK_LEN,
    BK_HDR,
    BK_RD,
    BK_CHUNK,
    BK_END
  } bk_e;

  typedef struct packed {
    op_e          op;
    logic         clear;
    logic [9:0]   base;
    lstat_e       status;
    logic [7:0]   csum;
    logic [255:0] ent;
  } qent_t;

  localparam logic [1:0]  REG_FAT32    = 2'd0;

  localparam logic [7:0]  BYTE_END     = 8'h00;
  localparam logic [7:0]  BYTE_DELETED = 8'hE5;
  localparam logic [7:0]  BYTE_KANJI   = 8'h05;
  localparam logic [7:0]  ATTR_MASK    = 8'h3F;
  localparam logic [7:0]  ATTR_LFN     = 8'h0F;
  localparam logic [7:0]  ATTR_VOLUME  = 8'h08;
  localparam logic [7:0]  ORD_FIRST    = 8'h40;
  localparam logic [7:0]  CHAR_SPACE   = 8'h20;
  localparam logic [7:0]  CHAR_DOT     = 8'h2E;
  localparam logic [7:0]  CHAR_QMARK   = 8'h3F;
  localparam logic [15:0] CHAR_NONE    = 16'hFFFF;
  localparam logic [15:0] ASCII_LIMIT  = 16'h0080;
  localparam logic [3:0]  LFN_LAST     = 4'd12;
  localparam logic [3:0]  SUM_LAST     = 4'd10;

  function automatic logic [4:0] char_pos(input logic [3:0] i);
    logic [4:0] p;
    case (i)
      4'd0:    p = 5'd1;
      4'd1:    p = 5'd3;
      4'd2:    p = 5'd5;
      4'd3:    p = 5'd7;
      4'd4:    p = 5'd9;
      4'd5:    p = 5'd14;
      4'd6:    p = 5'd16;
      4'd7:    p = 5'd18;
      4'd8:    p = 5'd20;
      4'd9:    p = 5'd22;
      4'd10:   p = 5'd24;
      4'd11:   p = 5'd28;
      4'd12:   p = 5'd30;
      default: p = 5'd1;
    endcase
    return p;
  endfunction

  function automatic logic [15:0] lfn_char(input logic [255:0] e, input logic [3:0] i);
    logic [4:0] p;
    p = char_pos(i);
    return e[{p, 3'b000} +: 16];
  endfunction

endpackage

[sv/fatde_front.sv]
// front end: accepts entries, tracks long-name state and queues work
module fatde_front #(
  parameter int NAME_MAX = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic [255:0]          ent_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output fatde_pkg::qent_t      qd_o
);

  logic                dir_q, dir_d;
  fatde_pkg::lstat_e   stat_q, stat_d;
  logic [7:0]          csum_q, csum_d;
  logic                acc;
  logic [7:0]          b0, b11, b13;
  logic [5:0]          ord, ord_m1;
  logic [9:0]          base;
  logic                trunc;
  logic [15:0]         ch;
  logic [10:0]         pos;

  assign in_ready_o = !q_full_i;
  assign acc = in_valid_i && !q_full_i;
  assign b0  = ent_i[7:0];
  assign b11 = ent_i[95:88];
  assign b13 = ent_i[111:104];
  assign ord = b0[5:0];
  assign ord_m1 = ord - 6'd1;
  assign base = {1'b0, ord_m1, 3'b000} + {2'b00, ord_m1, 2'b00} + {4'b0000, ord_m1};

  always_comb begin
    trunc = 1'b0;
    for (int i = 0; i < 13; i++) begin
      ch  = fatde_pkg::lfn_char(ent_i, 4'(i));
      pos = 11'(base) + 11'(i);
      if (ch != 16'h0000 && ch != fatde_pkg::CHAR_NONE && pos >= 11'(NAME_MAX - 1)) begin
        trunc = 1'b1;
      end
    end
  end

  always_comb begin
    dir_d  = dir_q;
    stat_d = stat_q;
    csum_d = csum_q;
    push_o = 1'b0;
    qd_o.op     = fatde_pkg::OP_END;
    qd_o.clear  = 1'b0;
    qd_o.base   = base;
    qd_o.status = stat_q;
    qd_o.csum   = csum_q;
    qd_o.ent    = ent_i;
    if (acc) begin
      if (!action_i) begin
        dir_d  = 1'b0;
        stat_d = fatde_pkg::LN_NONE;
      end else if (dir_q) begin
        push_o = 1'b1;
      end else if (b0 == fatde_pkg::BYTE_END) begin
        dir_d  = 1'b1;
        push_o = 1'b1;
      end else if (b0 == fatde_pkg::BYTE_DELETED) begin
        stat_d = fatde_pkg::LN_NONE;
      end else if ((b11 & fatde_pkg::ATTR_MASK) == fatde_pkg::ATTR_LFN) begin
        if ((b0 & fatde_pkg::ORD_FIRST) != 8'h00) begin
          csum_d = b13;
          push_o = 1'b1;
          if (ord == 6'd0) begin
            qd_o.op = fatde_pkg::OP_CLEAR;
            stat_d  = fatde_pkg::LN_NONE;
          end else begin
            qd_o.op    = fatde_pkg::OP_FRAG;
            qd_o.clear = 1'b1;
            stat_d     = trunc ? fatde_pkg::LN_TRUNC : fatde_pkg::LN_VALID;
          end
        end else if (stat_q == fatde_pkg::LN_NONE || b13 != csum_q || ord == 6'd0) begin
          stat_d = fatde_pkg::LN_NONE;
        end else begin
          push_o  = 1'b1;
          qd_o.op = fatde_pkg::OP_FRAG;
          if (trunc) begin
            stat_d = fatde_pkg::LN_TRUNC;
          end
        end
      end else if ((b11 & fatde_pkg::ATTR_VOLUME) != 8'h00) begin
        stat_d = fatde_pkg::LN_NONE;
      end else begin
        push_o  = 1'b1;
        qd_o.op = fatde_pkg::OP_SHORT;
        stat_d  = fatde_pkg::LN_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= 1'b0;
      stat_q <= fatde_pkg::LN_NONE;
      csum_q <= 8'h00;
    end else begin
      dir_q  <= dir_d;
      stat_q <= stat_d;
      csum_q <= csum_d;
    end
  end

endmodule

[sv/fatde_queue.sv]
// two-entry queue between front and back end
module fatde_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fatde_pkg::qent_t data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output fatde_pkg::qent_t data_o
);

  fatde_pkg::qent_t slot_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

[sv/fatde_back.sv]
// back end: name store, checksum, name length and result streaming
module fatde_back #(
  parameter int NAME_MAX = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fat32_i,
  input  logic             q_valid_i,
  output logic             q_pop_o,
  input  fatde_pkg::qent_t q_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       attributes_o,
  output logic [31:0]      file_size_o,
  output logic [31:0]      first_cluster_o,
  output logic [7:0]       name_length_o,
  output logic             name_truncated_o,
  output logic             long_name_used_o,
  output logic [63:0]      name_chunk_o,
  output logic             last_o
);

  localparam int ROWS = (NAME_MAX + 7) / 8;
  localparam int RW   = $clog2(ROWS);
  localparam int PW   = RW + 3;
  localparam int VW   = ROWS * 8;

  fatde_pkg::bk_e   state_q, state_d;
  fatde_pkg::qent_t ent_q;
  logic [3:0]       cnt_q, cnt_d;
  logic [7:0]       sum_q, sum_d;
  logic             long_q, long_d;
  logic [7:0]       len_q, len_d;
  logic [RW-1:0]    row_q, row_d;
  logic [VW-1:0]    valid_q;
  logic [63:0]      mem [ROWS];
  logic [63:0]      rdata_q;

  logic             ov_q;
  fatde_pkg::kind_e kind_q;
  logic [7:0]       attr_q;
  logic [31:0]      size_q, clus_q;
  logic [7:0]       nlen_q;
  logic             trunc_q, ulong_q, last_q;
  logic [63:0]      chunk_q;

  logic             out_free, load_out, last_chunk, use_long;
  logic [15:0]      ch;
  logic [10:0]      pos;
  logic             wr;
  logic [PW-1:0]    waddr;
  logic [7:0]       wdata;
  logic [VW-1:0]    veff;
  logic [7:0]       vrow;
  logic             zfound;
  logic [2:0]       zidx;
  logic [7:0]       b [12];
  logic [7:0]       sn [12];
  logic [3:0]       n8, ne, rawlen, slen, off;
  logic             has_ext, stop;
  logic [63:0]      cdata, cmask;
  logic [8:0]       pidx;

  assign out_free = !ov_q || out_ready_i;
  assign last_chunk = (9'({row_q, 3'b000}) + 9'd8) >= {1'b0, len_q};

  // 8.3 name formatting
  always_comb begin
    for (int i = 0; i < 12; i++) begin
      b[i] = ent_q.ent[8*i +: 8];
    end
    n8 = 4'd0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (b[i] == fatde_pkg::CHAR_SPACE) begin
        stop = 1'b1;
      end
      if (!stop) begin
        n8 = n8 + 4'd1;
      end
    end
    has_ext = b[8] != fatde_pkg::CHAR_SPACE;
    ne = 4'd0;
    stop = 1'b0;
    for (int i = 8; i < 11; i++) begin
      if (b[i] == fatde_pkg::CHAR_SPACE) begin
        stop = 1'b1;
      end
      if (!stop) begin
        ne = ne + 4'd1;
      end
    end
    for (int p = 0; p < 12; p++) begin
      off = 4'(p) - n8 - 4'd1;
      sn[p] = 8'h00;
      if (4'(p) < n8) begin
        sn[p] = (p == 0 && b[0] == fatde_pkg::BYTE_KANJI) ? fatde_pkg::BYTE_DELETED : b[p];
      end else if (has_ext && 4'(p) == n8) begin
        sn[p] = fatde_pkg::CHAR_DOT;
      end else if (has_ext && off < ne) begin
        sn[p] = b[8 + int'(off[1:0])];
      end
    end
    rawlen = n8 + (has_ext ? ne + 4'd1 : 4'd0);
    slen = rawlen;
    stop = 1'b0;
    for (int p = 0; p < 12; p++) begin
      if (!stop && 4'(p) < rawlen && sn[p] == 8'h00) begin
        slen = 4'(p);
        stop = 1'b1;
      end
    end
  end

  // long-name fragment write
  always_comb begin
    ch    = fatde_pkg::lfn_char(ent_q.ent, cnt_q);
    pos   = 11'(ent_q.base) + 11'(cnt_q);
    wr    = state_q == fatde_pkg::BK_FRAG && ch != 16'h0000 &&
            ch != fatde_pkg::CHAR_NONE && pos < 11'(NAME_MAX - 1);
    waddr = pos[PW-1:0];
    wdata = (ch < fatde_pkg::ASCII_LIMIT) ? ch[7:0] : fatde_pkg::CHAR_QMARK;
  end

  // long name length scan
  always_comb begin
    for (int j = 0; j < VW; j++) begin
      veff[j] = valid_q[j] && (j < NAME_MAX - 1);
    end
    vrow = veff[{row_q, 3'b000} +: 8];
    zfound = 1'b0;
    zidx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!vrow[i]) begin
        zfound = 1'b1;
        zidx = 3'(i);
      end
    end
  end

  always_comb begin
    sum_d    = {sum_q[0], sum_q[7:1]} + ent_q.ent[{cnt_q, 3'b000} +: 8];
    use_long = ent_q.status != fatde_pkg::LN_NONE && sum_d == ent_q.csum;
  end

  // chunk data
  always_comb begin
    if (long_q) begin
      cdata = rdata_q;
    end else if (row_q == '0) begin
      cdata = {sn[7], sn[6], sn[5], sn[4], sn[3], sn[2], sn[1], sn[0]};
    end else begin
      cdata = {32'h0, sn[11], sn[10], sn[9], sn[8]};
    end
    for (int i = 0; i < 8; i++) begin
      pidx = 9'({row_q, 3'(i)});
      cmask[8*i +: 8] = (pidx < {1'b0, len_q}) ? 8'hFF : 8'h00;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fatde_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          case (q_data_i.op)
            fatde_pkg::OP_END:   state_d = fatde_pkg::BK_END;
            fatde_pkg::OP_FRAG:  state_d = fatde_pkg::BK_FRAG;
            fatde_pkg::OP_SHORT: state_d = fatde_pkg::BK_CSUM;
            default:             state_d = fatde_pkg::BK_IDLE;
          endcase
        end
      end
      fatde_pkg::BK_FRAG: begin
        if (cnt_q == fatde_pkg::LFN_LAST) state_d = fatde_pkg::BK_IDLE;
      end
      fatde_pkg::BK_CSUM: begin
        if (cnt_q == fatde_pkg::SUM_LAST) begin
          state_d = use_long ? fatde_pkg::BK_LEN : fatde_pkg::BK_HDR;
        end
      end
      fatde_pkg::BK_LEN: begin
        if (zfound) state_d = fatde_pkg::BK_HDR;
      end
      fatde_pkg::BK_HDR: begin
        if (out_free) state_d = (len_q == 8'd0) ? fatde_pkg::BK_IDLE : fatde_pkg::BK_RD;
      end
      fatde_pkg::BK_RD: state_d = fatde_pkg::BK_CHUNK;
      fatde_pkg::BK_CHUNK: begin
        if (out_free) state_d = last_chunk ? fatde_pkg::BK_IDLE : fatde_pkg::BK_RD;
      end
      fatde_pkg::BK_END: begin
        if (out_free) state_d = fatde_pkg::BK_IDLE;
      end
      default: state_d = fatde_pkg::BK_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    q_pop_o  = state_q == fatde_pkg::BK_IDLE && q_valid_i;
    cnt_d    = cnt_q + 4'd1;
    long_d   = long_q;
    len_d    = len_q;
    row_d    = row_q;
    load_out = 1'b0;
    case (state_q)
      fatde_pkg::BK_IDLE: cnt_d = 4'd0;
      fatde_pkg::BK_CSUM: begin
        if (cnt_q == fatde_pkg::SUM_LAST) begin
          long_d = use_long;
          len_d  = 8'(slen);
          row_d  = '0;
        end
      end
      fatde_pkg::BK_LEN: begin
        if (zfound) begin
          len_d = 8'({row_q, zidx});
        end else begin
          row_d = row_q + RW'(1);
        end
      end
      fatde_pkg::BK_HDR: begin
        load_out = out_free;
        row_d    = '0;
      end
      fatde_pkg::BK_CHUNK: begin
        load_out = out_free;
        if (out_free) row_d = row_q + RW'(1);
      end
      fatde_pkg::BK_END: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem[waddr[PW-1:3]][{waddr[2:0], 3'b000} +: 8] <= wdata;
    end
    rdata_q <= mem[row_q];
    if (q_pop_o) begin
      ent_q <= q_data_i;
    end
    cnt_q  <= cnt_d;
    sum_q  <= (state_q == fatde_pkg::BK_CSUM) ? sum_d : 8'h00;
    long_q <= long_d;
    len_q  <= len_d;
    row_q  <= row_d;
    if (load_out) begin
      attr_q  <= 8'h00;
      size_q  <= 32'h0;
      clus_q  <= 32'h0;
      nlen_q  <= 8'h00;
      trunc_q <= 1'b0;
      ulong_q <= 1'b0;
      chunk_q <= 64'h0;
      last_q  <= 1'b1;
      case (state_q)
        fatde_pkg::BK_HDR: begin
          kind_q  <= fatde_pkg::KIND_HEADER;
          attr_q  <= b[11];
          size_q  <= ent_q.ent[255:224];
          clus_q  <= {fat32_i ? ent_q.ent[175:160] : 16'h0000, ent_q.ent[223:208]};
          nlen_q  <= len_q;
          trunc_q <= long_q && ent_q.status == fatde_pkg::LN_TRUNC;
          ulong_q <= long_q;
          last_q  <= len_q == 8'd0;
        end
        fatde_pkg::BK_CHUNK: begin
          kind_q  <= fatde_pkg::KIND_CHUNK;
          chunk_q <= cdata & cmask;
          last_q  <= last_chunk;
        end
        default: kind_q <= fatde_pkg::KIND_END;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fatde_pkg::BK_IDLE;
      valid_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop_o && (q_data_i.op == fatde_pkg::OP_CLEAR ||
                      (q_data_i.op == fatde_pkg::OP_FRAG && q_data_i.clear))) begin
        valid_q <= '0;
      end else if (wr) begin
        valid_q[waddr] <= 1'b1;
      end
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = ov_q;
  assign kind_o           = kind_q;
  assign attributes_o     = attr_q;
  assign file_size_o      = size_q;
  assign first_cluster_o  = clus_q;
  assign name_length_o    = nlen_q;
  assign name_truncated_o = trunc_q;
  assign long_name_used_o = ulong_q;
  assign name_chunk_o     = chunk_q;
  assign last_o           = last_q;

endmodule

[sv/fat_directory_entry_parser.sv]
// top level of the fat directory entry parser
// Parses 32-byte FAT directory entries, one per input transfer. The front end
// takes an entry and queues work for the back end through a two-entry queue.
// In the back end a long-name fragment writes one name character per cycle,
// an end-of-directory entry gives one end record, and a short entry runs a
// checksum, a name length scan for a long name, then one header and each
// 8-character chunk through a read state and a chunk state, paced by the
// single read port of the name store and held by out_ready_i. Deleted entries,
// volume labels and directory starts finish in the front end. fat32_mode sits
// at byte address 0 of the APB port.
module fat_directory_entry_parser #(
  parameter int NAME_MAX = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [63:0] entry_bytes_0_7_i,
  input  logic [63:0] entry_bytes_8_15_i,
  input  logic [63:0] entry_bytes_16_23_i,
  input  logic [63:0] entry_bytes_24_31_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  attributes_o,
  output logic [31:0] file_size_o,
  output logic [31:0] first_cluster_o,
  output logic [7:0]  name_length_o,
  output logic        name_truncated_o,
  output logic        long_name_used_o,
  output logic [63:0] name_chunk_o,
  output logic        last_o
);

  logic             fat32_q;
  logic             q_full, q_push, q_valid, q_pop;
  fatde_pkg::qent_t q_in, q_out;

  assign pready = 1'b1;
  assign prdata = (paddr == fatde_pkg::REG_FAT32) ? {31'h0, fat32_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fat32_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == fatde_pkg::REG_FAT32) begin
      fat32_q <= pwdata[0];
    end
  end

  fatde_front #(.NAME_MAX(NAME_MAX)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .ent_i      ({entry_bytes_24_31_i, entry_bytes_16_23_i,
                  entry_bytes_8_15_i, entry_bytes_0_7_i}),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .qd_o       (q_in)
  );

  fatde_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_out)
  );

  fatde_back #(.NAME_MAX(NAME_MAX)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fat32_i          (fat32_q),
    .q_valid_i        (q_valid),
    .q_pop_o          (q_pop),
    .q_data_i         (q_out),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .attributes_o     (attributes_o),
    .file_size_o      (file_size_o),
    .first_cluster_o  (first_cluster_o),
    .name_length_o    (name_length_o),
    .name_truncated_o (name_truncated_o),
    .long_name_used_o (long_name_used_o),
    .name_chunk_o     (name_chunk_o),
    .last_o           (last_o)
  );

endmodule
